/* sv/jete_pkg.sv */
`timescale 1ns / 1ps

package jete_pkg;

    // Number of buttons with a held bit.
    localparam int BUTTON_COUNT = 32;
    localparam int BTN_IDX_W    = (BUTTON_COUNT > 1) ? $clog2(BUTTON_COUNT) : 1;

    // Event source codes.
    localparam logic [7:0] TYPE_BUTTON = 8'd1;
    localparam logic [7:0] TYPE_AXIS   = 8'd2;

    // Axis numbers: two horizontal and two vertical axes.
    localparam logic [7:0] AXIS_X0 = 8'd0;
    localparam logic [7:0] AXIS_Y0 = 8'd1;
    localparam logic [7:0] AXIS_X1 = 8'd6;
    localparam logic [7:0] AXIS_Y1 = 8'd7;

    // First button that takes its keycode from the high base.
    localparam logic [7:0] BUTTON_SPLIT = 8'd10;

    // Configuration port.
    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    typedef enum logic [2:0] {
        REG_UP_KEY      = 3'd0,
        REG_DOWN_KEY    = 3'd1,
        REG_LEFT_KEY    = 3'd2,
        REG_RIGHT_KEY   = 3'd3,
        REG_DEAD_LOW    = 3'd4,
        REG_DEAD_HIGH   = 3'd5,
        REG_BTN_LOW     = 3'd6,
        REG_BTN_HIGH    = 3'd7
    } reg_idx_t;

    localparam logic [7:0]         RST_UP_KEY    = 8'd98;
    localparam logic [7:0]         RST_DOWN_KEY  = 8'd104;
    localparam logic [7:0]         RST_LEFT_KEY  = 8'd100;
    localparam logic [7:0]         RST_RIGHT_KEY = 8'd102;
    localparam logic signed [15:0] RST_DEAD_LOW  = -16'sd100;
    localparam logic [14:0]        RST_DEAD_HIGH = 15'd100;
    localparam logic [7:0]         RST_BTN_LOW   = 8'd10;
    localparam logic [7:0]         RST_BTN_HIGH  = 8'd24;

    // Output queue.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    typedef struct packed {
        logic [7:0]         up_key;
        logic [7:0]         down_key;
        logic [7:0]         left_key;
        logic [7:0]         right_key;
        logic signed [15:0] dead_low;
        logic [14:0]        dead_high;
        logic [7:0]         button_low_base;
        logic [7:0]         button_high_base;
    } cfg_t;

    typedef struct packed {
        logic [7:0]         event_type;
        logic [7:0]         event_number;
        logic signed [15:0] event_value;
    } joy_item_t;

    typedef struct packed {
        logic [7:0] key_code;
        logic       is_press;
        logic       last_of_run;
    } key_ev_t;

    typedef struct packed {
        logic [1:0] count;
        key_ev_t    ev0;
        key_ev_t    ev1;
    } map_res_t;

    typedef struct packed {
        logic [OQ_CNT_W-1:0] count;
        logic                room;
    } oq_stat_t;

endpackage

/* sv/jete_cfg.sv */
`timescale 1ns / 1ps

module jete_cfg (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [jete_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [jete_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [jete_pkg::CFG_DATA_W-1:0]   prdata,
    output jete_pkg::cfg_t                    cfg
);
    import jete_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx   = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
    assign wr_en = psel && penable && pwrite;
    assign cfg   = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.up_key           <= RST_UP_KEY;
            cfg_reg.down_key         <= RST_DOWN_KEY;
            cfg_reg.left_key         <= RST_LEFT_KEY;
            cfg_reg.right_key        <= RST_RIGHT_KEY;
            cfg_reg.dead_low         <= RST_DEAD_LOW;
            cfg_reg.dead_high        <= RST_DEAD_HIGH;
            cfg_reg.button_low_base  <= RST_BTN_LOW;
            cfg_reg.button_high_base <= RST_BTN_HIGH;
        end else if (wr_en) begin
            unique case (idx)
                REG_UP_KEY:    cfg_reg.up_key           <= pwdata[7:0];
                REG_DOWN_KEY:  cfg_reg.down_key         <= pwdata[7:0];
                REG_LEFT_KEY:  cfg_reg.left_key         <= pwdata[7:0];
                REG_RIGHT_KEY: cfg_reg.right_key        <= pwdata[7:0];
                REG_DEAD_LOW:  cfg_reg.dead_low         <= $signed(pwdata[15:0]);
                REG_DEAD_HIGH: cfg_reg.dead_high        <= pwdata[14:0];
                REG_BTN_LOW:   cfg_reg.button_low_base  <= pwdata[7:0];
                REG_BTN_HIGH:  cfg_reg.button_high_base <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (idx)
            REG_UP_KEY:    prdata = {24'd0, cfg_reg.up_key};
            REG_DOWN_KEY:  prdata = {24'd0, cfg_reg.down_key};
            REG_LEFT_KEY:  prdata = {24'd0, cfg_reg.left_key};
            REG_RIGHT_KEY: prdata = {24'd0, cfg_reg.right_key};
            REG_DEAD_LOW:  prdata = {{16{cfg_reg.dead_low[15]}}, cfg_reg.dead_low};
            REG_DEAD_HIGH: prdata = {17'd0, cfg_reg.dead_high};
            REG_BTN_LOW:   prdata = {24'd0, cfg_reg.button_low_base};
            REG_BTN_HIGH:  prdata = {24'd0, cfg_reg.button_high_base};
            default:       prdata = '0;
        endcase
    end

endmodule

/* sv/jete_map.sv */
`timescale 1ns / 1ps

module jete_map (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                fire,
    input  jete_pkg::joy_item_t item,
    input  jete_pkg::cfg_t      cfg,
    output jete_pkg::map_res_t  res
);
    import jete_pkg::*;

    logic                    up_held_reg;
    logic                    down_held_reg;
    logic                    left_held_reg;
    logic                    right_held_reg;
    logic [BUTTON_COUNT-1:0] button_held_reg;

    logic                 is_pos;
    logic                 is_neg;
    logic                 vert;
    logic                 horiz;
    logic                 neg_held;
    logic                 pos_held;
    logic [7:0]           neg_key;
    logic [7:0]           pos_key;
    logic                 btn_hit;
    logic [BTN_IDX_W-1:0] btn_idx;
    logic                 pressed;
    logic                 btn_change;
    logic [7:0]           btn_key;
    logic                 a_v;
    logic                 b_v;
    key_ev_t              a_ev;
    key_ev_t              b_ev;

    // The positive test is made first, so an inverted dead zone favors positive.
    assign is_pos = $signed(item.event_value) > $signed({1'b0, cfg.dead_high});
    assign is_neg = !is_pos && ($signed(item.event_value) < $signed(cfg.dead_low));

    assign vert  = (item.event_type == TYPE_AXIS) &&
                   (item.event_number == AXIS_Y0 || item.event_number == AXIS_Y1);
    assign horiz = (item.event_type == TYPE_AXIS) &&
                   (item.event_number == AXIS_X0 || item.event_number == AXIS_X1);

    // Negative side is up or left, positive side is down or right.
    assign neg_held = vert ? up_held_reg   : left_held_reg;
    assign pos_held = vert ? down_held_reg : right_held_reg;
    assign neg_key  = vert ? cfg.up_key    : cfg.left_key;
    assign pos_key  = vert ? cfg.down_key  : cfg.right_key;

    assign btn_hit    = (item.event_type == TYPE_BUTTON) &&
                        ({1'b0, item.event_number} < 9'(BUTTON_COUNT));
    assign btn_idx    = item.event_number[BTN_IDX_W-1:0];
    assign pressed    = item.event_value[7:0] != 8'd0;
    assign btn_change = btn_hit && (button_held_reg[btn_idx] != pressed);
    assign btn_key    = (item.event_number < BUTTON_SPLIT)
                      ? cfg.button_low_base + item.event_number
                      : cfg.button_high_base + (item.event_number - BUTTON_SPLIT);

    always_comb begin
        a_v  = 1'b0;
        b_v  = 1'b0;
        a_ev = '0;
        b_ev = '0;
        if (vert || horiz) begin
            if (is_pos) begin
                a_v  = neg_held;
                a_ev = '{key_code: neg_key, is_press: 1'b0, last_of_run: 1'b0};
                b_v  = !pos_held;
                b_ev = '{key_code: pos_key, is_press: 1'b1, last_of_run: 1'b0};
            end else if (is_neg) begin
                a_v  = pos_held;
                a_ev = '{key_code: pos_key, is_press: 1'b0, last_of_run: 1'b0};
                b_v  = !neg_held;
                b_ev = '{key_code: neg_key, is_press: 1'b1, last_of_run: 1'b0};
            end else begin
                a_v  = neg_held;
                a_ev = '{key_code: neg_key, is_press: 1'b0, last_of_run: 1'b0};
                b_v  = pos_held;
                b_ev = '{key_code: pos_key, is_press: 1'b0, last_of_run: 1'b0};
            end
        end else begin
            b_v  = btn_change;
            b_ev = '{key_code: btn_key, is_press: pressed, last_of_run: 1'b0};
        end
    end

    // Pack the valid events to the front and mark the final one.
    always_comb begin
        res.count = {1'b0, a_v} + {1'b0, b_v};
        res.ev0   = a_v ? a_ev : b_ev;
        res.ev0.last_of_run = !(a_v && b_v);
        res.ev1   = b_ev;
        res.ev1.last_of_run = 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            up_held_reg     <= 1'b0;
            down_held_reg   <= 1'b0;
            left_held_reg   <= 1'b0;
            right_held_reg  <= 1'b0;
            button_held_reg <= '0;
        end else if (fire) begin
            if (vert) begin
                up_held_reg   <= is_neg;
                down_held_reg <= is_pos;
            end
            if (horiz) begin
                left_held_reg  <= is_neg;
                right_held_reg <= is_pos;
            end
            if (btn_hit) begin
                button_held_reg[btn_idx] <= pressed;
            end
        end
    end

endmodule

/* sv/jete_outq.sv */
`timescale 1ns / 1ps

module jete_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  jete_pkg::map_res_t res,
    input  logic               pop,
    output logic               ev_valid,
    output jete_pkg::key_ev_t  ev,
    output jete_pkg::oq_stat_t stat
);
    import jete_pkg::*;

    key_ev_t             mem_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg;
    logic [OQ_PTR_W-1:0] rd_ptr_reg;
    logic [OQ_CNT_W-1:0] count_reg;
    logic [OQ_CNT_W-1:0] count_next;
    logic [OQ_CNT_W-1:0] push_n;
    logic                do_pop;

    assign push_n   = push ? OQ_CNT_W'(res.count) : '0;
    assign do_pop   = pop && ev_valid;
    assign ev_valid = count_reg != '0;
    assign ev       = mem_reg[rd_ptr_reg];

    // Room for the two events that the worst-case item makes.
    assign stat.count = count_reg;
    assign stat.room  = count_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    assign count_next = count_reg + push_n - OQ_CNT_W'(do_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + push_n[OQ_PTR_W-1:0];
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && res.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= res.ev0;
        end
        if (push && res.count == 2'd2) begin
            mem_reg[wr_ptr_reg + OQ_PTR_W'(1)] <= res.ev1;
        end
    end

endmodule

/* sv/joystick_event_to_key_events.sv */
`timescale 1ns / 1ps
// Joystick event to key event converter.
// The s_ channel takes one joystick event per transfer; s_tdata carries
// event_type, event_number and event_value. An axis event yields zero to two
// key events (release of the old key, then press of the new one); a button
// event yields at most one. Each key event leaves on the m_ channel, with
// m_tlast set on the final key event of one input.
// A key event passes through the input register and then the output queue before
// it is offered on m_; while the queue lacks room it waits in the input register.
// The second key event of a pair leaves the queue after the first.
// Throughput: one input per cycle while the four-entry output queue has room
// for two key events; m_ moves one key event per cycle while m_tready is high,
// so an input that yields two key events takes two transfers on m_.
// The keycodes and dead zone sit in an APB register file; write them only
// while the block is idle.
// Reset (aresetn low, synchronous) restores the register defaults, releases
// every key and button and empties the queue.
// When the receiver stalls, results wait in the queue and the input register
// holds one more event; s_tready falls once the queue lacks room for two.
module joystick_event_to_key_events (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // event_type, event_number, event_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata,   // key_code, is_press, zero fill
    output logic                            m_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [jete_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [jete_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [jete_pkg::CFG_DATA_W-1:0] prdata,
    output logic                            pready
);
    import jete_pkg::*;

    cfg_t      cfg;
    joy_item_t in_item_reg;
    logic      in_valid_reg;
    logic      fire;
    map_res_t  res;
    oq_stat_t  stat;
    key_ev_t   ev;

    assign pready = 1'b1;

    jete_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    assign fire     = in_valid_reg && stat.room;
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.event_type   <= s_tdata[7:0];
            in_item_reg.event_number <= s_tdata[15:8];
            in_item_reg.event_value  <= $signed(s_tdata[31:16]);
        end
    end

    jete_map u_map (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (in_item_reg),
        .cfg     (cfg),
        .res     (res)
    );

    jete_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (fire),
        .res      (res),
        .pop      (m_tready),
        .ev_valid (m_tvalid),
        .ev       (ev),
        .stat     (stat)
    );

    assign m_tdata = {7'd0, ev.is_press, ev.key_code};
    assign m_tlast = ev.last_of_run;

`ifndef SYNTHESIS
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.count <= OQ_CNT_W'(OQ_DEPTH))
        else $error("output queue holds more events than it has entries");

    a_button_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && in_item_reg.event_type == TYPE_BUTTON) |-> (res.count <= 2'd1))
        else $error("button event produced more than one key event");

    a_result_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.count != 2'd0) |=> m_tvalid)
        else $error("key event was not offered after its input was processed");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && res.count == 2'd2) |-> (!res.ev0.last_of_run && res.ev1.last_of_run))
        else $error("last marker misplaced in a pair of key events");
`endif

endmodule

/* tb/joystick_event_to_key_events_test.sv */
`timescale 1ns / 1ps

module joystick_event_to_key_events_test;
    import jete_pkg::*;

    // Predicts the key events of each joystick event and checks them in order.
    class key_scoreboard;
        cfg_t    cfg;
        bit      up_held, down_held, left_held, right_held;
        bit      button_held [BUTTON_COUNT];
        key_ev_t expected_keys [$];
        key_ev_t run_keys [$];
        int      mismatches;
        int      keys_checked;
        int      events_noted;

        function new();
            cfg = '{RST_UP_KEY, RST_DOWN_KEY, RST_LEFT_KEY, RST_RIGHT_KEY,
                    RST_DEAD_LOW, RST_DEAD_HIGH, RST_BTN_LOW, RST_BTN_HIGH};
            up_held = 0;
            down_held = 0;
            left_held = 0;
            right_held = 0;
            foreach (button_held[i]) button_held[i] = 0;
            mismatches = 0;
            keys_checked = 0;
            events_noted = 0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_UP_KEY:    cfg.up_key = value[7:0];
                REG_DOWN_KEY:  cfg.down_key = value[7:0];
                REG_LEFT_KEY:  cfg.left_key = value[7:0];
                REG_RIGHT_KEY: cfg.right_key = value[7:0];
                REG_DEAD_LOW:  cfg.dead_low = value[15:0];
                REG_DEAD_HIGH: cfg.dead_high = value[14:0];
                REG_BTN_LOW:   cfg.button_low_base = value[7:0];
                REG_BTN_HIGH:  cfg.button_high_base = value[7:0];
                default: ;
            endcase
        endfunction

        function void add_key(logic [7:0] code, bit press);
            key_ev_t k;
            k.key_code = code;
            k.is_press = press;
            k.last_of_run = 1'b0;
            run_keys.push_back(k);
        endfunction

        // The positive test is made first, so it wins when the dead zone is inverted.
        function void drive_pair(int v, inout bit neg, inout bit pos,
                                 logic [7:0] neg_key, logic [7:0] pos_key);
            int hi;
            int lo;
            hi = int'(cfg.dead_high);
            lo = int'(cfg.dead_low);
            if (v > hi) begin
                if (neg) add_key(neg_key, 1'b0);
                if (!pos) add_key(pos_key, 1'b1);
                neg = 0;
                pos = 1;
            end else if (v < lo) begin
                if (pos) add_key(pos_key, 1'b0);
                if (!neg) add_key(neg_key, 1'b1);
                neg = 1;
                pos = 0;
            end else begin
                if (neg) add_key(neg_key, 1'b0);
                if (pos) add_key(pos_key, 1'b0);
                neg = 0;
                pos = 0;
            end
        endfunction

        function void note_event(joy_item_t ev);
            int         v;
            bit         pressed;
            logic [7:0] code;
            run_keys.delete();
            events_noted++;
            v = int'(ev.event_value);
            if (ev.event_type == TYPE_AXIS) begin
                if (ev.event_number == AXIS_Y0 || ev.event_number == AXIS_Y1)
                    drive_pair(v, up_held, down_held, cfg.up_key, cfg.down_key);
                else if (ev.event_number == AXIS_X0 || ev.event_number == AXIS_X1)
                    drive_pair(v, left_held, right_held, cfg.left_key, cfg.right_key);
            end else if (ev.event_type == TYPE_BUTTON && ev.event_number < BUTTON_COUNT) begin
                pressed = (ev.event_value[7:0] != 8'd0);
                if (button_held[ev.event_number] != pressed) begin
                    // Keycode sums wrap at eight bits.
                    if (ev.event_number < BUTTON_SPLIT)
                        code = cfg.button_low_base + ev.event_number;
                    else
                        code = cfg.button_high_base + (ev.event_number - BUTTON_SPLIT);
                    add_key(code, pressed);
                    button_held[ev.event_number] = pressed;
                end
            end
            if (run_keys.size() > 0) run_keys[run_keys.size() - 1].last_of_run = 1'b1;
            foreach (run_keys[i]) expected_keys.push_back(run_keys[i]);
        endfunction

        function int pending();
            return expected_keys.size();
        endfunction

        task flag(string what);
            mismatches++;
            if (mismatches <= 40) $display("mismatch: %s", what);
        endtask

        task check_key(key_ev_t got);
            key_ev_t want;
            keys_checked++;
            if (expected_keys.size() == 0) begin
                flag($sformatf("key event code %0d press %0b last %0b with none expected",
                               got.key_code, got.is_press, got.last_of_run));
                return;
            end
            want = expected_keys.pop_front();
            if (got.key_code != want.key_code)
                flag($sformatf("key event %0d: key_code %0d, expected %0d",
                               keys_checked, got.key_code, want.key_code));
            if (got.is_press != want.is_press)
                flag($sformatf("key event %0d: is_press %0b, expected %0b",
                               keys_checked, got.is_press, want.is_press));
            if (got.last_of_run != want.last_of_run)
                flag($sformatf("key event %0d: last_of_run %0b, expected %0b",
                               keys_checked, got.last_of_run, want.last_of_run));
        endtask

        task check_leftovers();
            if (expected_keys.size() != 0)
                flag($sformatf("%0d expected key events never came", expected_keys.size()));
        endtask
    endclass

    logic                  aclk = 0;
    logic                  aresetn = 0;
    logic                  s_tvalid = 0;
    logic                  s_tready;
    logic [31:0]           s_tdata = '0;    // event_type, event_number, event_value
    logic                  m_tvalid;
    logic                  m_tready = 0;
    logic [15:0]           m_tdata;         // key_code, is_press, zero fill
    logic                  m_tlast;
    logic                  psel = 0;
    logic                  penable = 0;
    logic                  pwrite = 0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    key_scoreboard board = new();
    bit            steady = 0;
    int            hold_left = 0;

    joystick_event_to_key_events uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d key events outstanding", board.pending());
        $display("*** FAILED ***");
        $finish;
    end

    // Receiver: random stalls, a quiet phase, and a long hold-off on request.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= steady || ($urandom_range(99) >= 14);
            end
        end
    end

    always @(posedge aclk) begin
        key_ev_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.key_code = m_tdata[7:0];
            got.is_press = m_tdata[8];
            got.last_of_run = m_tlast;
            board.check_key(got);
        end
    end

    function automatic joy_item_t make_event(logic [7:0] kind, logic [7:0] num,
                                             logic [15:0] v);
        joy_item_t ev;
        ev.event_type = kind;
        ev.event_number = num;
        ev.event_value = v;
        return ev;
    endfunction

    function automatic joy_item_t random_event();
        int          r;
        int          pick;
        int          v;
        logic [7:0]  num;
        logic [15:0] raw;
        r = $urandom_range(99);
        if (r < 45) begin
            pick = $urandom_range(3);
            num = (pick == 0) ? AXIS_X0 : (pick == 1) ? AXIS_Y0 :
                  (pick == 2) ? AXIS_X1 : AXIS_Y1;
            pick = $urandom_range(9);
            if (pick < 3) begin
                raw = 16'($urandom_range(16'hFFFF));
            end else if (pick < 5) begin
                pick = $urandom_range(2);
                raw = (pick == 0) ? 16'h7FFF : (pick == 1) ? 16'h8000 : 16'h0000;
            end else begin
                // Around the edges of the dead zone.
                if ($urandom_range(1))
                    v = int'(board.cfg.dead_high);
                else
                    v = int'(board.cfg.dead_low);
                v = v + int'($urandom_range(4)) - 2;
                raw = v[15:0];
            end
            return make_event(TYPE_AXIS, num, raw);
        end else if (r < 85) begin
            num = ($urandom_range(9) == 0) ? 8'($urandom_range(255, BUTTON_COUNT))
                                            : 8'($urandom_range(BUTTON_COUNT - 1));
            raw[15:8] = 8'($urandom_range(255));
            raw[7:0] = $urandom_range(1) ? 8'($urandom_range(255, 1)) : 8'd0;
            return make_event(TYPE_BUTTON, num, raw);
        end
        return make_event(8'($urandom_range(255)), 8'($urandom_range(255)),
                          16'($urandom_range(16'hFFFF)));
    endfunction

    task automatic send_event(joy_item_t ev);
        s_tdata <= {ev.event_value, ev.event_number, ev.event_type};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        board.note_event(ev);
        if (!steady && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    // Lets every expected key event drain, then waits on for inputs that
    // produce nothing but may still be in flight.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_register(idx, value);
    endtask

    task automatic program_setting(logic [7:0] up, logic [7:0] down, logic [7:0] left,
                                   logic [7:0] right, logic [15:0] lo, logic [14:0] hi,
                                   logic [7:0] btn_lo, logic [7:0] btn_hi);
        write_reg(REG_UP_KEY, {24'd0, up});
        write_reg(REG_DOWN_KEY, {24'd0, down});
        write_reg(REG_LEFT_KEY, {24'd0, left});
        write_reg(REG_RIGHT_KEY, {24'd0, right});
        write_reg(REG_DEAD_LOW, {16'd0, lo});
        write_reg(REG_DEAD_HIGH, {17'd0, hi});
        write_reg(REG_BTN_LOW, {24'd0, btn_lo});
        write_reg(REG_BTN_HIGH, {24'd0, btn_hi});
    endtask

    task automatic program_random();
        program_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                        8'($urandom_range(255)), 8'($urandom_range(255)),
                        16'(0 - $urandom_range(32768)), 15'($urandom_range(32767)),
                        8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // Runs with the reset register values: dead zone -100 to 100.
    task automatic run_directed();
        send_event(make_event(TYPE_AXIS, AXIS_Y0, 16'h7FFF));
        send_event(make_event(TYPE_AXIS, AXIS_Y1, 16'h8000));
        send_event(make_event(TYPE_AXIS, AXIS_Y0, 16'd100));
        send_event(make_event(TYPE_AXIS, AXIS_Y0, 16'd101));
        send_event(make_event(TYPE_AXIS, AXIS_Y1, 16'hFF9C));
        send_event(make_event(TYPE_AXIS, AXIS_Y1, 16'hFF9B));
        send_event(make_event(TYPE_AXIS, AXIS_Y0, 16'd0));
        send_event(make_event(TYPE_AXIS, AXIS_X0, 16'h7FFF));
        send_event(make_event(TYPE_AXIS, AXIS_X1, 16'h8000));
        send_event(make_event(TYPE_AXIS, AXIS_X0, 16'd0));
        send_event(make_event(TYPE_AXIS, 8'd3, 16'h7FFF));
        send_event(make_event(8'd0, AXIS_Y0, 16'h7FFF));
        send_event(make_event(8'd255, AXIS_X0, 16'h8000));
        send_event(make_event(8'd3, 8'd0, 16'd1));
        send_event(make_event(TYPE_BUTTON, 8'd0, 16'd1));
        send_event(make_event(TYPE_BUTTON, 8'd0, 16'h0100));
        send_event(make_event(TYPE_BUTTON, 8'd0, 16'd0));
        send_event(make_event(TYPE_BUTTON, 8'd9, 16'h00FF));
        send_event(make_event(TYPE_BUTTON, BUTTON_SPLIT, 16'hFFFF));
        send_event(make_event(TYPE_BUTTON, 8'd31, 16'h0080));
        send_event(make_event(TYPE_BUTTON, 8'd32, 16'd1));
        send_event(make_event(TYPE_BUTTON, 8'd255, 16'd1));
        send_event(make_event(TYPE_BUTTON, 8'd31, 16'h8000));
        send_event(make_event(TYPE_BUTTON, 8'd9, 16'd0));
        send_event(make_event(TYPE_BUTTON, BUTTON_SPLIT, 16'd0));
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                1: program_setting(8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'h8000, 15'h7FFF,
                                   8'hFF, 8'hFF);
                2: begin
                    steady = 1;
                    program_setting(8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 15'd0, 8'd0, 8'd0);
                end
                3: begin
                    // Inverted dead zone and button bases that wrap.
                    steady = 0;
                    program_setting(8'($urandom_range(255)), 8'($urandom_range(255)),
                                    8'($urandom_range(255)), 8'($urandom_range(255)),
                                    16'd300, 15'd200, 8'd250, 8'd240);
                end
                4, 5: program_random();
                default: ;
            endcase
            if (phase == 0) run_directed();
            for (int n = 0; n < 155; n++) begin
                if (phase == 4 && n == 20) hold_left = 400;
                if (phase == 5 && n == 70) wait_drained();
                send_event(random_event());
            end
            wait_drained();
        end
        repeat (10) @(posedge aclk);
        board.check_leftovers();
        $display("Sent %0d joystick events under six register settings; checked %0d key events.",
                 board.events_noted, board.keys_checked);
        $display("Settings included reset values, both extremes and an inverted dead zone.");
        if (board.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches", board.mismatches);
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

/* joystick_event_to_key_events.f */
sv/jete_pkg.sv
sv/jete_cfg.sv
sv/jete_map.sv
sv/jete_outq.sv
sv/joystick_event_to_key_events.sv
tb/joystick_event_to_key_events_test.sv
